FILE: rtl/table_linear_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table linear interpolator
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TLI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tli: implication check failed");
`define TLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tli: next-cycle check failed");
`else
`define TLI_ASSERT_IMP(label, ante, cons)
`define TLI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 7;
    localparam int PROD_W     = 65;
    localparam int QUO_W      = 33;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic [5:0]                 point_index;
        logic signed [DATA_W-1:0]   point_x;
        logic signed [DATA_W-1:0]   point_y;
        logic signed [DATA_W-1:0]   query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   result_y;
        logic                       clamped;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHK_ENDS,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SEG_LO,
        ST_SEG_HI,
        ST_SEG_CAP,
        ST_WAIT_MD,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL_LO,
        MD_MUL_HI,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef struct packed {
        logic               start;
        logic [QUO_W-1:0]   mag;
        logic [DATA_W-1:0]  t;
        logic [DATA_W-1:0]  dx;
    } md_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [QUO_W-1:0]   quo;
    } md_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/tli_muldiv.sv
// ----------------------------------------------------------------------------
// tli_muldiv
// Computes mag * t / dx: two-step multiply, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_muldiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tli_pkg::md_req_t req,
    output tli_pkg::md_rsp_t     rsp
);

    tli_pkg::md_state_t state_reg, state_next;

    logic [tli_pkg::QUO_W-1:0]  mag_reg;
    logic [tli_pkg::DATA_W-1:0] t_reg;
    logic [tli_pkg::DATA_W-1:0] dx_reg;
    logic [tli_pkg::PROD_W-1:0] prod_reg;
    logic [tli_pkg::DATA_W-1:0] rem_reg;
    logic [tli_pkg::QUO_W-1:0]  low_reg;
    logic [tli_pkg::DCNT_W-1:0] cnt_reg;

    logic [tli_pkg::PROD_W-1:0] prod_full;
    logic [tli_pkg::DATA_W:0]   rem_shift;
    logic [tli_pkg::DATA_W:0]   rem_sub;
    logic                       rem_ge;
    logic                       last_step;

    // t <= dx, so the quotient fits 33 bits and the top 32 product bits stay below dx
    assign prod_full = prod_reg
        + (tli_pkg::PROD_W'(mag_reg * t_reg[31:16]) << 16);
    assign rem_shift = {rem_reg, low_reg[tli_pkg::QUO_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dx_reg};
    assign rem_ge    = (rem_shift >= {1'b0, dx_reg});
    assign last_step = (cnt_reg == tli_pkg::DCNT_W'(tli_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tli_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = tli_pkg::MD_MUL_LO;
                end
            end
            tli_pkg::MD_MUL_LO: state_next = tli_pkg::MD_MUL_HI;
            tli_pkg::MD_MUL_HI: state_next = tli_pkg::MD_DIV;
            tli_pkg::MD_DIV:
            begin
                if (last_step)
                begin
                    state_next = tli_pkg::MD_DONE;
                end
            end
            tli_pkg::MD_DONE:   state_next = tli_pkg::MD_IDLE;
            default:            state_next = tli_pkg::MD_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.busy = (state_reg != tli_pkg::MD_IDLE);
        rsp.done = (state_reg == tli_pkg::MD_DONE);
        rsp.quo  = low_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tli_pkg::MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tli_pkg::MD_MUL_HI)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == tli_pkg::MD_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tli_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    mag_reg <= req.mag;
                    t_reg   <= req.t;
                    dx_reg  <= req.dx;
                end
            end
            tli_pkg::MD_MUL_LO:
            begin
                prod_reg <= tli_pkg::PROD_W'(mag_reg * t_reg[15:0]);
            end
            tli_pkg::MD_MUL_HI:
            begin
                rem_reg <= prod_full[tli_pkg::PROD_W-1:tli_pkg::QUO_W];
                low_reg <= prod_full[tli_pkg::QUO_W-1:0];
            end
            tli_pkg::MD_DIV:
            begin
                rem_reg <= rem_ge ? rem_sub[tli_pkg::DATA_W-1:0]
                                  : rem_shift[tli_pkg::DATA_W-1:0];
                low_reg <= {low_reg[tli_pkg::QUO_W-2:0], rem_ge};
            end
            tli_pkg::MD_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_core
// 1-D piecewise linear interpolation over a breakpoint table held in RAM.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid / in_stall / in_data    load or query transaction in
//  out       out_valid / out_stall / out_data one result per query
//  cfg       cfg_we / cfg_wdata               points_in_use write
//
//  A load is one write to both RAMs. A query at or past the table ends
//  goes straight to the result without the search; an interior query runs
//  the binary search reads of the x RAM and then the bit-serial divide.
//  Reset clears control state only; table entries are undefined until
//  loaded. A stalled result holds the output register; loads continue to
//  be accepted while it waits, as long as the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "table_linear_interpolator_core_defines.svh"

module table_linear_interpolator_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire tli_pkg::in_item_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output tli_pkg::out_item_t               out_data,
    input  wire logic                        cfg_we,
    input  wire logic [tli_pkg::CFG_W-1:0]   cfg_wdata
);

    tli_pkg::state_t state_reg, state_next;

    logic [tli_pkg::CNT_W-1:0]         n_cfg_reg;
    logic [tli_pkg::CNT_W-1:0]         n_reg;
    logic [tli_pkg::CNT_W-1:0]         lo_reg;
    logic [tli_pkg::CNT_W-1:0]         hi_reg;
    logic [tli_pkg::IDX_W-1:0]         seg_reg;
    logic signed [tli_pkg::DATA_W-1:0] qx_reg;
    logic signed [tli_pkg::DATA_W-1:0] ax_reg;
    logic signed [tli_pkg::DATA_W-1:0] ay_reg;
    logic                              neg_reg;
    logic signed [tli_pkg::DATA_W-1:0] res_reg;
    logic                              clamp_reg;
    logic                              out_valid_reg;
    tli_pkg::out_item_t                out_data_reg;

    logic                              in_acc;
    logic                              load_we;
    logic [tli_pkg::IDX_W-1:0]         rd_addr;
    logic [tli_pkg::DATA_W-1:0]        x_rdata;
    logic [tli_pkg::DATA_W-1:0]        y_rdata;
    logic signed [tli_pkg::DATA_W-1:0] xr;
    logic signed [tli_pkg::DATA_W-1:0] yr;

    logic [tli_pkg::CNT_W:0]           mid_sum;
    logic [tli_pkg::CNT_W-1:0]         mid;
    logic [tli_pkg::CNT_W-1:0]         nm1;
    logic [tli_pkg::CNT_W-1:0]         seg_sel;
    logic signed [tli_pkg::DATA_W:0]   dx;
    logic signed [tli_pkg::DATA_W:0]   dy;
    logic signed [tli_pkg::DATA_W:0]   tq;
    logic [tli_pkg::DATA_W:0]          mag;
    logic [tli_pkg::DATA_W-1:0]        t_cl;
    logic                              dx_pos;
    logic signed [tli_pkg::DATA_W+1:0] sum;
    logic signed [tli_pkg::DATA_W-1:0] sum_sat;
    logic                              can_emit;
    logic [tli_pkg::CNT_W-1:0]         cfg_clip;

    tli_pkg::md_req_t md_req;
    tli_pkg::md_rsp_t md_rsp;

    assign xr = x_rdata;
    assign yr = y_rdata;

    assign in_acc  = in_valid && !in_stall;
    assign load_we = in_acc && (in_data.opcode == tli_pkg::OP_LOAD)
                     && ({1'b0, in_data.point_index} < tli_pkg::CNT_W'(tli_pkg::MAX_POINTS));

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[tli_pkg::CNT_W:1];
    assign nm1     = n_reg - 1'b1;

    // keep the segment end inside 1..n-1
    always_comb
    begin
        priority if (lo_reg < tli_pkg::CNT_W'(1))
        begin
            seg_sel = tli_pkg::CNT_W'(1);
        end
        else if (lo_reg > nm1)
        begin
            seg_sel = nm1;
        end
        else
        begin
            seg_sel = lo_reg;
        end
    end

    assign dx     = {xr[tli_pkg::DATA_W-1], xr} - {ax_reg[tli_pkg::DATA_W-1], ax_reg};
    assign dy     = {yr[tli_pkg::DATA_W-1], yr} - {ay_reg[tli_pkg::DATA_W-1], ay_reg};
    assign tq     = {qx_reg[tli_pkg::DATA_W-1], qx_reg} - {ax_reg[tli_pkg::DATA_W-1], ax_reg};
    assign dx_pos = !dx[tli_pkg::DATA_W] && (dx != '0);
    assign mag    = dy[tli_pkg::DATA_W] ? (-dy) : dy;

    always_comb
    begin
        priority if (tq[tli_pkg::DATA_W])
        begin
            t_cl = '0;
        end
        else if (tq > dx)
        begin
            t_cl = dx[tli_pkg::DATA_W-1:0];
        end
        else
        begin
            t_cl = tq[tli_pkg::DATA_W-1:0];
        end
    end

    assign sum = neg_reg
        ? ({{2{ay_reg[tli_pkg::DATA_W-1]}}, ay_reg} - {1'b0, md_rsp.quo})
        : ({{2{ay_reg[tli_pkg::DATA_W-1]}}, ay_reg} + {1'b0, md_rsp.quo});

    always_comb
    begin
        priority if (sum[tli_pkg::DATA_W+1] && !(&sum[tli_pkg::DATA_W:tli_pkg::DATA_W-1]))
        begin
            sum_sat = {1'b1, {(tli_pkg::DATA_W-1){1'b0}}};
        end
        else if (!sum[tli_pkg::DATA_W+1] && (|sum[tli_pkg::DATA_W:tli_pkg::DATA_W-1]))
        begin
            sum_sat = {1'b0, {(tli_pkg::DATA_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[tli_pkg::DATA_W-1:0];
        end
    end

    assign can_emit = !out_valid_reg || !out_stall;

    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            cfg_clip = tli_pkg::CNT_W'(1);
        end
        else if (tli_pkg::CNT_W'(cfg_wdata) > tli_pkg::CNT_W'(tli_pkg::MAX_POINTS))
        begin
            cfg_clip = tli_pkg::CNT_W'(tli_pkg::MAX_POINTS);
        end
        else
        begin
            cfg_clip = tli_pkg::CNT_W'(cfg_wdata);
        end
    end

    tli_ram #(
        .WIDTH (tli_pkg::DATA_W),
        .DEPTH (tli_pkg::MAX_POINTS)
    ) u_x_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (in_data.point_index[tli_pkg::IDX_W-1:0]),
        .wdata (in_data.point_x),
        .raddr (rd_addr),
        .rdata (x_rdata)
    );

    tli_ram #(
        .WIDTH (tli_pkg::DATA_W),
        .DEPTH (tli_pkg::MAX_POINTS)
    ) u_y_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (in_data.point_index[tli_pkg::IDX_W-1:0]),
        .wdata (in_data.point_y),
        .raddr (rd_addr),
        .rdata (y_rdata)
    );

    tli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                if (in_acc && (in_data.opcode == tli_pkg::OP_QUERY))
                begin
                    state_next = tli_pkg::ST_RD_FIRST;
                end
            end
            tli_pkg::ST_RD_FIRST: state_next = tli_pkg::ST_RD_LAST;
            tli_pkg::ST_RD_LAST:  state_next = tli_pkg::ST_CHK_ENDS;
            tli_pkg::ST_CHK_ENDS:
            begin
                if ((qx_reg <= ax_reg) || (qx_reg >= xr))
                begin
                    state_next = tli_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = tli_pkg::ST_SRCH_RD;
                end
            end
            tli_pkg::ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = tli_pkg::ST_SRCH_CMP;
                end
                else
                begin
                    state_next = tli_pkg::ST_SEG_LO;
                end
            end
            tli_pkg::ST_SRCH_CMP: state_next = tli_pkg::ST_SRCH_RD;
            tli_pkg::ST_SEG_LO:   state_next = tli_pkg::ST_SEG_HI;
            tli_pkg::ST_SEG_HI:   state_next = tli_pkg::ST_SEG_CAP;
            tli_pkg::ST_SEG_CAP:
            begin
                if (dx_pos)
                begin
                    state_next = tli_pkg::ST_WAIT_MD;
                end
                else
                begin
                    state_next = tli_pkg::ST_FINISH;
                end
            end
            tli_pkg::ST_WAIT_MD:
            begin
                if (md_rsp.done)
                begin
                    state_next = tli_pkg::ST_FINISH;
                end
            end
            tli_pkg::ST_FINISH:
            begin
                if (can_emit)
                begin
                    state_next = tli_pkg::ST_IDLE;
                end
            end
            default: state_next = tli_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall   = (state_reg != tli_pkg::ST_IDLE);
        rd_addr    = '0;
        md_req     = '0;
        md_req.mag = mag;
        md_req.t   = t_cl;
        md_req.dx  = dx[tli_pkg::DATA_W-1:0];
        unique case (state_reg)
            tli_pkg::ST_RD_LAST:  rd_addr = nm1[tli_pkg::IDX_W-1:0];
            tli_pkg::ST_SRCH_RD:  rd_addr = mid[tli_pkg::IDX_W-1:0];
            tli_pkg::ST_SEG_LO:   rd_addr = seg_sel[tli_pkg::IDX_W-1:0] - 1'b1;
            tli_pkg::ST_SEG_HI:   rd_addr = seg_reg;
            tli_pkg::ST_SEG_CAP:  md_req.start = dx_pos;
            default:              rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tli_pkg::ST_IDLE;
            n_cfg_reg     <= tli_pkg::CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                n_cfg_reg <= cfg_clip;
            end
            if ((state_reg == tli_pkg::ST_FINISH) && can_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                qx_reg <= in_data.query_x;
                n_reg  <= n_cfg_reg;
            end
            tli_pkg::ST_RD_LAST:
            begin
                ax_reg <= xr;
                ay_reg <= yr;
            end
            tli_pkg::ST_CHK_ENDS:
            begin
                lo_reg <= '0;
                hi_reg <= n_reg;
                priority if (qx_reg <= ax_reg)
                begin
                    res_reg   <= ay_reg;
                    clamp_reg <= (qx_reg < ax_reg);
                end
                else if (qx_reg >= xr)
                begin
                    res_reg   <= yr;
                    clamp_reg <= (qx_reg > xr);
                end
                else
                begin
                    clamp_reg <= 1'b0;
                end
            end
            tli_pkg::ST_SRCH_CMP:
            begin
                if (xr < qx_reg)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            tli_pkg::ST_SEG_LO:
            begin
                seg_reg <= seg_sel[tli_pkg::IDX_W-1:0];
            end
            tli_pkg::ST_SEG_HI:
            begin
                ax_reg <= xr;
                ay_reg <= yr;
            end
            tli_pkg::ST_SEG_CAP:
            begin
                neg_reg <= dy[tli_pkg::DATA_W];
                res_reg <= ay_reg;
            end
            tli_pkg::ST_WAIT_MD:
            begin
                if (md_rsp.done)
                begin
                    res_reg <= sum_sat;
                end
            end
            tli_pkg::ST_FINISH:
            begin
                if (can_emit)
                begin
                    out_data_reg.result_y <= res_reg;
                    out_data_reg.clamped  <= clamp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TLI_ASSERT_IMP(a_n_in_range, 1'b1, (n_cfg_reg != '0) && (n_cfg_reg <= tli_pkg::CNT_W'(tli_pkg::MAX_POINTS)))
    `TLI_ASSERT_IMP(a_search_bounds, state_reg == tli_pkg::ST_SRCH_RD, (lo_reg <= hi_reg) && (hi_reg <= n_reg))
    `TLI_ASSERT_IMP(a_seg_in_table, state_reg == tli_pkg::ST_SEG_HI, (seg_reg != '0) && ({1'b0, seg_reg} < n_reg))
    `TLI_ASSERT_IMP(a_md_done_waited, md_rsp.done, state_reg == tli_pkg::ST_WAIT_MD)
    `TLI_ASSERT_NEXT(a_query_starts, in_acc && (in_data.opcode == tli_pkg::OP_QUERY), state_reg == tli_pkg::ST_RD_FIRST)

endmodule

`default_nettype wire
